// ----- hw/rtl/i2csbe_pkg.sv -----
// Shared types and constants for the I2C slave bit engine.
package i2csbe_pkg;

    localparam int TX_DEPTH = 256;
    localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

    localparam logic [1:0] KIND_SCL  = 2'd0;
    localparam logic [1:0] KIND_SDA  = 2'd1;
    localparam logic [1:0] KIND_LOAD = 2'd2;

    localparam logic [2:0] BUS_PHASE_IDLE  = 3'd0;
    localparam logic [2:0] BUS_PHASE_START = 3'd1;
    localparam logic [2:0] BUS_PHASE_DATA  = 3'd2;
    localparam logic [2:0] BUS_PHASE_ACK   = 3'd3;
    localparam logic [2:0] BUS_PHASE_NACK  = 3'd4;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    typedef struct packed {
        logic [7:0] load_byte;
        logic [7:0] load_index;
        logic       sda_level;
        logic       scl_level;
        logic [1:0] kind;
    } item_t;

    typedef struct packed {
        logic [2:0] bus_phase;
        logic [7:0] rx_position;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       sda_value;
        logic       sda_drive;
    } result_t;

endpackage

// ----- hw/rtl/i2csbe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module i2csbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/i2csbe_tx_buffer.sv -----
// Transmit byte store: RAM plus write bypass, presents the byte at the transmit pointer.
module i2csbe_tx_buffer (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     accept,
    input  i2csbe_pkg::item_t        item,
    input  logic [i2csbe_pkg::TX_AW-1:0] rd_addr,
    output logic [7:0]               tx_byte
);
    import i2csbe_pkg::*;

    logic [TX_AW+7:0] load_wide;
    logic [TX_AW-1:0] load_addr;
    logic             load_en;
    logic [7:0]       ram_q;
    logic             byp_valid_reg;
    logic             byp_valid_next;
    logic [7:0]       byp_data_reg;

    assign load_wide = {{TX_AW{1'b0}}, item.load_index};
    assign load_addr = load_wide[TX_AW-1:0];
    assign load_en   = accept && (item.kind == KIND_LOAD)
                       && (32'(item.load_index) < 32'(TX_DEPTH));

    // rd_addr is re-read every cycle; a write to it this cycle is forwarded
    assign byp_valid_next = load_en && (load_addr == rd_addr);

    i2csbe_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (load_en),
        .wr_addr (load_addr),
        .wr_data (item.load_byte),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_valid_reg <= 1'b0;
        end else begin
            byp_valid_reg <= byp_valid_next;
        end
        byp_data_reg <= item.load_byte;
    end

    assign tx_byte = byp_valid_reg ? byp_data_reg : ram_q;

endmodule

// ----- hw/rtl/i2csbe_core.sv -----
// Bus state machine: START/STOP detection, bit and byte counting, ACK and SDA drive.
module i2csbe_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [6:0]                   cfg_wr_data,
    input  logic                         accept,
    input  i2csbe_pkg::item_t            item,
    input  logic [7:0]                   tx_byte,
    output logic [i2csbe_pkg::TX_AW-1:0] tx_ptr_next,
    output i2csbe_pkg::result_t          result
);
    import i2csbe_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE  = BUS_PHASE_IDLE,
        PH_START = BUS_PHASE_START,
        PH_DATA  = BUS_PHASE_DATA,
        PH_ACK   = BUS_PHASE_ACK,
        PH_NACK  = BUS_PHASE_NACK
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [3:0]       fall_count_reg, fall_count_next;
    logic             read_mode_reg, read_mode_next;
    logic             matched_reg, matched_next;
    logic [7:0]       shift_reg, shift_next;
    logic [7:0]       rx_count_reg, rx_count_next;
    logic [TX_AW-1:0] tx_ptr_reg, tx_ptr_calc;
    logic             drv_on_reg, drv_on_next;
    logic             drv_val_reg, drv_val_next;
    logic [6:0]       slave_address_reg;
    logic [3:0]       fc_inc;
    logic             rx_valid;
    logic [7:0]       rx_byte;
    logic [7:0]       rx_position;

    assign fc_inc = fall_count_reg + 4'd1;

    always_comb begin
        phase_next      = phase_reg;
        fall_count_next = fall_count_reg;
        read_mode_next  = read_mode_reg;
        matched_next    = matched_reg;
        shift_next      = shift_reg;
        rx_count_next   = rx_count_reg;
        tx_ptr_calc     = tx_ptr_reg;
        drv_on_next     = drv_on_reg;
        drv_val_next    = drv_val_reg;
        rx_valid        = 1'b0;
        rx_byte         = 8'd0;
        rx_position     = 8'd0;
        unique case (item.kind)
            KIND_SCL: begin
                if (item.scl_level) begin
                    if (phase_reg == PH_DATA) begin
                        if (!read_mode_reg && (fall_count_reg < 4'd8) && item.sda_level) begin
                            shift_next[~fall_count_reg[2:0]] = 1'b1;
                        end
                    end else if (phase_reg == PH_ACK) begin
                        if (read_mode_reg && item.sda_level) begin
                            phase_next = PH_NACK;
                        end
                    end
                end else begin
                    unique case (phase_reg)
                        PH_START: begin
                            fall_count_next = 4'd0;
                            rx_count_next   = 8'd0;
                            tx_ptr_calc     = '0;
                            matched_next    = 1'b0;
                            shift_next      = 8'd0;
                            read_mode_next  = 1'b0;
                            phase_next      = PH_DATA;
                        end
                        PH_DATA: begin
                            fall_count_next = fc_inc;
                            if (fc_inc < 4'd8) begin
                                if (read_mode_reg) begin
                                    drv_val_next = tx_byte[~fc_inc[2:0]];
                                end
                            end else begin
                                if (!read_mode_reg) begin
                                    if ((rx_count_reg == 8'd0)
                                        && (shift_reg[7:1] == slave_address_reg)) begin
                                        matched_next   = 1'b1;
                                        read_mode_next = shift_reg[0];
                                    end
                                    if (matched_next) begin
                                        drv_on_next  = 1'b1;
                                        drv_val_next = 1'b0;
                                        rx_valid     = 1'b1;
                                        rx_byte      = shift_reg;
                                        rx_position  = rx_count_reg;
                                    end
                                end else begin
                                    drv_on_next = 1'b0;
                                    tx_ptr_calc = (tx_ptr_reg == TX_AW'(TX_DEPTH - 1))
                                                  ? '0 : tx_ptr_reg + TX_AW'(1);
                                end
                                phase_next = PH_ACK;
                            end
                        end
                        PH_ACK: begin
                            fall_count_next = 4'd0;
                            if (!read_mode_reg) begin
                                drv_on_next   = 1'b0;
                                rx_count_next = rx_count_reg + 8'd1;
                                shift_next    = 8'd0;
                            end else begin
                                drv_on_next  = 1'b1;
                                drv_val_next = tx_byte[7];
                            end
                            phase_next = PH_DATA;
                        end
                        PH_NACK: begin
                            fall_count_next = 4'd0;
                            drv_on_next     = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            KIND_SDA: begin
                if (item.scl_level) begin
                    phase_next = item.sda_level ? PH_IDLE : PH_START;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            fall_count_reg    <= 4'd0;
            read_mode_reg     <= 1'b0;
            matched_reg       <= 1'b0;
            shift_reg         <= 8'd0;
            rx_count_reg      <= 8'd0;
            tx_ptr_reg        <= '0;
            drv_on_reg        <= 1'b0;
            drv_val_reg       <= 1'b1;
            slave_address_reg <= 7'd0;
        end else begin
            if (cfg_wr_en) begin
                slave_address_reg <= cfg_wr_data;
            end
            if (accept) begin
                phase_reg      <= phase_next;
                fall_count_reg <= fall_count_next;
                read_mode_reg  <= read_mode_next;
                matched_reg    <= matched_next;
                shift_reg      <= shift_next;
                rx_count_reg   <= rx_count_next;
                tx_ptr_reg     <= tx_ptr_calc;
                drv_on_reg     <= drv_on_next;
                drv_val_reg    <= drv_val_next;
            end
        end
    end

    assign tx_ptr_next = accept ? tx_ptr_calc : tx_ptr_reg;

    assign result.sda_drive   = drv_on_next;
    assign result.sda_value   = drv_val_next;
    assign result.rx_valid    = rx_valid;
    assign result.rx_byte     = rx_byte;
    assign result.rx_position = rx_position;
    assign result.bus_phase   = phase_next;

endmodule

// ----- hw/rtl/i2c_slave_bit_engine_unit.sv -----
// Top level of the I2C slave bit engine: core, transmit store and output register.
//
//   channel  dir  handshake            payload
//   s_       in   s_tvalid/s_tready    s_tuser kind, s_tdata pin levels and load fields
//   m_       out  m_tvalid/m_tready    m_tdata drive, rx byte and bus phase
//   cfg_     in   cfg_wr_en            cfg_wr_data slave address
//
// One item per cycle while s_tready is high; one result per item, valid the next cycle.
// The transmit byte at the pointer is read from RAM ahead of use, addressed by the
// next pointer, with a bypass for a load to that same entry.
// s_tready is high while the output register is empty or being drained.
// Reset is synchronous; no clearing pass, transmit RAM contents are kept.
module i2c_slave_bit_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // kind
    input  logic [23:0] s_tdata,   // scl_level, sda_level, load_index[7:0], load_byte[7:0], pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // sda_drive, sda_value, rx_valid, rx_byte[7:0],
                                   // rx_position[7:0], bus_phase[2:0], pad
);
    import i2csbe_pkg::*;

    item_t            item;
    result_t          result;
    logic             accept;
    logic [7:0]       tx_byte;
    logic [TX_AW-1:0] tx_ptr_next;
    logic             m_tvalid_reg;
    logic [23:0]      m_tdata_reg;

    assign item.kind       = s_tuser;
    assign item.scl_level  = s_tdata[0];
    assign item.sda_level  = s_tdata[1];
    assign item.load_index = s_tdata[9:2];
    assign item.load_byte  = s_tdata[17:10];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    i2csbe_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .item        (item),
        .tx_byte     (tx_byte),
        .tx_ptr_next (tx_ptr_next),
        .result      (result)
    );

    i2csbe_tx_buffer u_tx_buffer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (item),
        .rd_addr (tx_ptr_next),
        .tx_byte (tx_byte)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (accept) begin
            m_tdata_reg <= {2'b00, result};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- hw/rtl/i2csbe_checker.sv -----
// Port-level assertions for the I2C slave bit engine, bound to the top level.
module i2csbe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    import i2csbe_pkg::*;

    // reported byte always comes with ACK driven low
    a_rx_ack_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |-> (m_tdata[0] && !m_tdata[1]))
        else $error("rx byte without ACK drive");

    a_rx_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |-> (m_tdata[21:19] == BUS_PHASE_ACK))
        else $error("rx byte outside ACK phase");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output register");

    a_accept_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted item gave no result");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind i2c_slave_bit_engine_unit i2csbe_checker u_checker (.*);
